[design/scp_pkg.sv]
package scp_pkg;

	// window depth and the widths that follow from it
	localparam int MAX_PATTERN = 16;
	localparam int IDX_W       = $clog2(MAX_PATTERN);
	localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
	localparam int NUM_HALF    = 8;

	localparam logic [7:0] STAR_CODE = 8'd42;

	typedef logic [7:0]        byte_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [FILL_W-1:0] fill_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_PAT_LO  = 2'd0,
		REG_PAT_HI  = 2'd1,
		REG_PAT_LEN = 2'd2
	} cfg_reg_t;

	// window control from the sequencer to the cells
	typedef struct packed {
		logic shift;
		logic append;
		idx_t append_pos;
	} win_ctl_t;

	// active pattern length: zero acts as one, above the depth clamps
	function automatic fill_t clamp_len(input logic [4:0] raw);
		fill_t len;
		if (raw == 5'd0) begin
			len = fill_t'(1);
		end else if ({1'b0, raw} > 6'(MAX_PATTERN)) begin
			len = fill_t'(MAX_PATTERN);
		end else begin
			len = fill_t'(raw);
		end
		return len;
	endfunction

endpackage

[design/stream_pattern_censor.sv]
// The first result of a transaction passes through a window cell and then the output register.
// Throughput, while out_ready is high: one byte per cycle; a pattern hit emits one asterisk
//   per cycle and holds off input until its last asterisk, a flush until its last byte.
// Reset (arst_n low): window empty, output invalid, pattern zero, length one.
//   Window byte storage is not reset.
module stream_pattern_censor
	import scp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// input byte stream
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	// censored output stream
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_of_run
);

	// Configuration registers. The length is clamped on write so the
	// datapath always sees an active length in 1..MAX_PATTERN.
	logic [63:0] pat_lo_q, pat_hi_q;
	fill_t       len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			len_q    <= fill_t'(1);
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PAT_LO:  pat_lo_q <= cfg_data;
				REG_PAT_HI:  pat_hi_q <= cfg_data;
				REG_PAT_LEN: len_q    <= clamp_len(cfg_data[4:0]);
				default: ;
			endcase
		end
	end

	// Window: a row of byte cells, oldest byte in cell 0. Every emitted
	// result (passed byte or asterisk) shifts the row by one toward cell 0,
	// so a hit drops its pattern bytes one per asterisk. A new byte lands
	// at the first free cell after that shift.
	win_ctl_t               win_ctl;
	byte_t                  win   [MAX_PATTERN];
	byte_t                  pat   [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] eq;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		byte_t nb;
		logic  ld;

		if (i < NUM_HALF) begin : g_lo
			assign pat[i] = pat_lo_q[8*i +: 8];
		end else if (i < 2*NUM_HALF) begin : g_hi
			assign pat[i] = pat_hi_q[8*(i-NUM_HALF) +: 8];
		end else begin : g_zero
			assign pat[i] = '0;
		end

		if (i == MAX_PATTERN - 1) begin : g_end
			assign nb = '0;
		end else begin : g_mid
			assign nb = win[i+1];
		end

		assign ld = win_ctl.append && (win_ctl.append_pos == idx_t'(i));

		scp_cell u_cell (
			.clk       (clk),
			.shift     (win_ctl.shift),
			.load      (ld),
			.din       (data_byte),
			.next_byte (nb),
			.pat_byte  (pat[i]),
			.cell_byte (win[i]),
			.eq        (eq[i])
		);
	end

	// Sequencer: fill count, asterisks still owed, pending flush and the
	// output register. It takes the next transaction in the same cycle
	// that the last result of the previous one is registered.
	scp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.len           (len_q),
		.eq            (eq),
		.head_byte     (win[0]),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.end_of_stream (end_of_stream),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.last_of_run   (last_of_run),
		.win_ctl       (win_ctl)
	);

endmodule

[design/scp_cell.sv]
module scp_cell
	import scp_pkg::*;
(
	input  logic  clk,
	input  logic  shift,
	input  logic  load,
	input  byte_t din,
	input  byte_t next_byte,
	input  byte_t pat_byte,
	output byte_t cell_byte,
	output logic  eq
);

	byte_t byte_q;

	// load wins: the new byte lands at the slot freed by the shift
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= din;
		end else if (shift) begin
			byte_q <= next_byte;
		end
	end

	assign cell_byte = byte_q;
	assign eq        = (byte_q == pat_byte);

endmodule

[design/scp_ctrl.sv]
module scp_ctrl
	import scp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  fill_t                  len,
	input  logic [MAX_PATTERN-1:0] eq,
	input  byte_t                  head_byte,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   end_of_stream,
	output logic                   out_valid,
	input  logic                   out_ready,
	output byte_t                  out_byte,
	output logic                   last_of_run,
	output win_ctl_t               win_ctl
);

	fill_t                  fill_q, fill_d, fill_m1;
	idx_t                   star_q, star_d, star_act;
	logic                   eos_q, eos_d;
	logic                   busy_q, busy_d;
	logic                   out_valid_q;
	byte_t                  out_byte_q, res_byte;
	logic                   last_q, res_last;
	logic                   do_act, out_load, emit, hit_now, match, accept;
	logic [MAX_PATTERN-1:0] mask;

	// only the first len window slots take part in the compare
	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			mask[k] = (FILL_W'(k) < len);
		end
	end
	assign match = &(eq | ~mask);

	// busy_q: a transaction has been taken and its results are not all out;
	// a backlog left by a shorter length waits for the next transaction
	assign fill_m1  = fill_q - fill_t'(1);
	assign do_act   = busy_q &&
		((star_q != '0) || (fill_q >= len) || (eos_q && (fill_q != '0)));
	assign out_load = !out_valid_q || out_ready;
	assign emit     = do_act && out_load;
	assign hit_now  = (star_q == '0) && (fill_q >= len) && match;

	always_comb begin
		if (star_q != '0) begin
			star_act = star_q - idx_t'(1);
		end else if (hit_now) begin
			star_act = idx_t'(len - fill_t'(1));
		end else begin
			star_act = '0;
		end
		res_byte = ((star_q != '0) || hit_now) ? STAR_CODE : head_byte;
		// last when nothing is left to do after this result
		res_last = !((star_act != '0) || (fill_m1 >= len) || (eos_q && (fill_m1 != '0)));
	end

	assign in_ready = !do_act || (emit && res_last);
	assign accept   = in_valid && in_ready;

	always_comb begin
		win_ctl.shift      = emit;
		win_ctl.append     = accept;
		win_ctl.append_pos = emit ? idx_t'(fill_m1) : idx_t'(fill_q);
		fill_d             = fill_q - fill_t'(emit) + fill_t'(accept);
		star_d             = emit ? star_act : star_q;
		if (accept) begin
			eos_d = end_of_stream;
		end else if (!do_act) begin
			eos_d = 1'b0;
		end else begin
			eos_d = eos_q;
		end
		if (accept) begin
			busy_d = 1'b1;
		end else if (!do_act || (emit && res_last)) begin
			busy_d = 1'b0;
		end else begin
			busy_d = busy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			star_q      <= '0;
			eos_q       <= 1'b0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			star_q <= star_d;
			eos_q  <= eos_d;
			busy_q <= busy_d;
			if (out_load) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= res_byte;
			last_q     <= res_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

endmodule
